// ===== design/mphh_pkg.sv =====
// Package for the mesh packet header parser and payload hasher.
// Holds the shared widths, header codes and the result item type.
// No dependencies.
`default_nettype none

package mphh_pkg;

    localparam int POS_W             = 8;
    localparam int OFFSET_W          = 9;
    localparam int HASH_W            = 16;
    localparam int MAX_PACKET_BYTES_DEF = 255;

    localparam logic [1:0] HDR_ROUTE_TRANSPORT_A = 2'b00;
    localparam logic [1:0] HDR_ROUTE_TRANSPORT_B = 2'b11;

    localparam logic [POS_W-1:0] PATH_IDX_TRANSPORT = 8'd5;
    localparam logic [POS_W-1:0] PATH_IDX_PLAIN     = 8'd1;

    localparam int HASH_SHL = 5;
    localparam int HASH_SHR = 11;

    typedef struct packed {
        logic        crc_error;
        logic [7:0]  header_byte;
        logic [7:0]  path_length_byte;
        logic        has_transport;
        logic [5:0]  hop_hash_count;
        logic [2:0]  hop_hash_size;
        logic [7:0]  payload_length;
        logic [15:0] body_hash;
    } result_t;

endpackage

`default_nettype wire

// ===== design/mphh_if.sv =====
// Stream interfaces of the mesh packet header parser.
// One carries packet bytes in, the other carries parse results out.
// No dependencies.
`default_nettype none

interface mphh_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;
    logic       crc_bad;

    modport source (output valid, output data_byte, output last_byte, output crc_bad,
                    input ready);
    modport sink   (input valid, input data_byte, input last_byte, input crc_bad,
                    output ready);
endinterface

interface mphh_result_if;
    logic        valid;
    logic        ready;
    logic        crc_error;
    logic [7:0]  header_byte;
    logic [7:0]  path_length_byte;
    logic        has_transport;
    logic [5:0]  hop_hash_count;
    logic [2:0]  hop_hash_size;
    logic [7:0]  payload_length;
    logic [15:0] body_hash;

    modport source (output valid, output crc_error, output header_byte,
                    output path_length_byte, output has_transport, output hop_hash_count,
                    output hop_hash_size, output payload_length, output body_hash,
                    input ready);
    modport sink   (input valid, input crc_error, input header_byte,
                    input path_length_byte, input has_transport, input hop_hash_count,
                    input hop_hash_size, input payload_length, input body_hash,
                    output ready);
endinterface

`default_nettype wire

// ===== design/mesh_packet_header_parse_hash.sv =====
// Mesh packet header parser and payload hasher: takes one packet byte per
// cycle on pkt and, on the byte marked last, delivers at most one result item
// on result in the following cycle from a single result register. A byte
// that ends no packet is accepted every cycle regardless of the output side;
// a last byte is accepted when the result register is empty or being taken
// in that cycle. The per-byte header parse and hash update are one register
// stage; the sustained rate is one byte per cycle while no last byte waits.
// Depends on mphh_pkg and mphh_if.
`default_nettype none

module mesh_packet_header_parse_hash #(
    parameter int MAX_PACKET_BYTES = mphh_pkg::MAX_PACKET_BYTES_DEF
) (
    input  wire           clk,
    input  wire           rst_n,
    mphh_byte_if.sink     pkt,
    mphh_result_if.source result
);
    import mphh_pkg::*;

    localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_PACKET_BYTES);

    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [7:0]          hdr_reg, hdr_next;
    logic [7:0]          plen_reg, plen_next;
    logic                seen_reg, seen_next;
    logic [OFFSET_W-1:0] offset_reg, offset_next;
    logic [HASH_W-1:0]   hash_reg, hash_next;

    logic                res_valid_reg, res_valid_next;
    result_t             res_reg, res_next;

    logic                accept;
    logic                active;
    logic                transport;
    logic [POS_W-1:0]    path_idx;
    logic [2:0]          size_in;
    logic [OFFSET_W-1:0] path_span;
    logic [POS_W-1:0]    pos_upd;
    logic [7:0]          hdr_upd;
    logic [7:0]          plen_upd;
    logic                seen_upd;
    logic [OFFSET_W-1:0] offset_upd;
    logic [HASH_W-1:0]   hash_upd;
    logic                emit;
    logic                upd_transport;
    logic [OFFSET_W-1:0] payload_diff;

    assign pkt.ready = !res_valid_reg || result.ready || !pkt.last_byte;
    assign accept    = pkt.valid && pkt.ready;

    assign active    = pos_reg < MAX_POS;
    assign transport = (hdr_reg[1:0] == HDR_ROUTE_TRANSPORT_A)
                    || (hdr_reg[1:0] == HDR_ROUTE_TRANSPORT_B);
    assign path_idx  = transport ? PATH_IDX_TRANSPORT : PATH_IDX_PLAIN;
    assign size_in   = {1'b0, pkt.data_byte[7:6]} + 3'd1;
    assign path_span = {3'b0, pkt.data_byte[5:0]} * {6'b0, size_in};

    always_comb
    begin
        pos_upd    = pos_reg;
        hdr_upd    = hdr_reg;
        plen_upd   = plen_reg;
        seen_upd   = seen_reg;
        offset_upd = offset_reg;
        hash_upd   = hash_reg;
        if (active)
        begin
            if (pos_reg == '0)
            begin
                hdr_upd = pkt.data_byte;
            end
            else if (!seen_reg && pos_reg == path_idx)
            begin
                plen_upd   = pkt.data_byte;
                seen_upd   = 1'b1;
                offset_upd = {1'b0, pos_reg} + OFFSET_W'(1) + path_span;
            end
            else if (seen_reg && {1'b0, pos_reg} >= offset_reg)
            begin
                hash_upd = {hash_reg[HASH_W-HASH_SHL-1:0], {HASH_SHL{1'b0}}}
                         ^ {{HASH_SHR{1'b0}}, hash_reg[HASH_W-1:HASH_SHR]}
                         ^ {8'b0, pkt.data_byte};
            end
            pos_upd = pos_reg + POS_W'(1);
        end
    end

    assign upd_transport = (hdr_upd[1:0] == HDR_ROUTE_TRANSPORT_A)
                        || (hdr_upd[1:0] == HDR_ROUTE_TRANSPORT_B);
    assign payload_diff  = {1'b0, pos_upd} - offset_upd;
    assign emit          = pkt.crc_bad || (pos_upd >= POS_W'(2) && seen_upd);

    always_comb
    begin
        res_next = '0;
        if (pkt.crc_bad)
        begin
            res_next.crc_error = 1'b1;
        end
        else
        begin
            res_next.header_byte      = hdr_upd;
            res_next.path_length_byte = plen_upd;
            res_next.has_transport    = upd_transport;
            res_next.hop_hash_count   = plen_upd[5:0];
            res_next.hop_hash_size    = {1'b0, plen_upd[7:6]} + 3'd1;
            if ({1'b0, pos_upd} > offset_upd)
            begin
                res_next.payload_length = payload_diff[7:0];
                res_next.body_hash      = hash_upd;
            end
        end
    end

    always_comb
    begin
        pos_next       = pos_reg;
        hdr_next       = hdr_reg;
        plen_next      = plen_reg;
        seen_next      = seen_reg;
        offset_next    = offset_reg;
        hash_next      = hash_reg;
        res_valid_next = res_valid_reg && !result.ready;
        if (accept)
        begin
            if (pkt.last_byte)
            begin
                pos_next       = '0;
                hdr_next       = '0;
                plen_next      = '0;
                seen_next      = 1'b0;
                offset_next    = '0;
                hash_next      = '0;
                res_valid_next = emit;
            end
            else
            begin
                pos_next    = pos_upd;
                hdr_next    = hdr_upd;
                plen_next   = plen_upd;
                seen_next   = seen_upd;
                offset_next = offset_upd;
                hash_next   = hash_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            hdr_reg       <= '0;
            plen_reg      <= '0;
            seen_reg      <= 1'b0;
            offset_reg    <= '0;
            hash_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            hdr_reg       <= hdr_next;
            plen_reg      <= plen_next;
            seen_reg      <= seen_next;
            offset_reg    <= offset_next;
            hash_reg      <= hash_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // load the result register only when a last byte goes in
    always_ff @(posedge clk)
    begin
        if (accept && pkt.last_byte)
        begin
            res_reg <= res_next;
        end
    end

    assign result.valid            = res_valid_reg;
    assign result.crc_error        = res_reg.crc_error;
    assign result.header_byte      = res_reg.header_byte;
    assign result.path_length_byte = res_reg.path_length_byte;
    assign result.has_transport    = res_reg.has_transport;
    assign result.hop_hash_count   = res_reg.hop_hash_count;
    assign result.hop_hash_size    = res_reg.hop_hash_size;
    assign result.payload_length   = res_reg.payload_length;
    assign result.body_hash        = res_reg.body_hash;

endmodule

`default_nettype wire

// ===== tb/mesh_packet_header_parse_hash_tb.sv =====
// Testbench for mesh_packet_header_parse_hash: random and directed packets in,
// each result item checked field by field against an in-bench tracker.
// Depends on mphh_pkg, mphh_if and the block's top module.
`timescale 1ns / 100ps

module mesh_packet_header_parse_hash_tb;

    import mphh_pkg::*;

    localparam int PKT_LIMIT    = MAX_PACKET_BYTES_DEF;
    localparam int LONG_HOLD    = 300;
    localparam int RANDOM_BYTES = 1300;
    localparam int LIMIT_NS     = 5_000_000;

    class parse_hash_tracker;
        logic [POS_W-1:0]    pos;
        logic [7:0]          hdr;
        logic [7:0]          plen;
        bit                  plen_seen;
        logic [OFFSET_W-1:0] body_start;
        logic [HASH_W-1:0]   hash;
        result_t             pending_results[$];
        int                  mismatches;

        function new();
            clear_packet();
            mismatches = 0;
        endfunction

        function void clear_packet();
            pos = '0;
            hdr = '0;
            plen = '0;
            plen_seen = 1'b0;
            body_start = '0;
            hash = '0;
        endfunction

        function bit transport_hdr(logic [7:0] h);
            return (h[1:0] == HDR_ROUTE_TRANSPORT_A) || (h[1:0] == HDR_ROUTE_TRANSPORT_B);
        endfunction

        function void take_byte(logic [7:0] b, bit last, bit crc);
            logic [POS_W-1:0] plen_pos;
            result_t          res;
            plen_pos = transport_hdr(hdr) ? PATH_IDX_TRANSPORT : PATH_IDX_PLAIN;
            if (int'(pos) < PKT_LIMIT)
            begin
                if (pos == 0)
                begin
                    hdr = b;
                end
                else if (!plen_seen && pos == plen_pos)
                begin
                    plen = b;
                    plen_seen = 1'b1;
                    body_start = OFFSET_W'(int'(pos) + 1 + int'(b[5:0]) * (int'(b[7:6]) + 1));
                end
                else if (plen_seen && {1'b0, pos} >= body_start)
                begin
                    hash = (hash << HASH_SHL) ^ (hash >> HASH_SHR) ^ {8'h00, b};
                end
                pos = pos + 1'b1;
            end
            if (!last)
                return;
            res = '0;
            if (crc)
            begin
                res.crc_error = 1'b1;
                pending_results.push_back(res);
            end
            else if (pos >= 2 && plen_seen)
            begin
                res.header_byte = hdr;
                res.path_length_byte = plen;
                res.has_transport = transport_hdr(hdr);
                res.hop_hash_count = plen[5:0];
                res.hop_hash_size = {1'b0, plen[7:6]} + 3'd1;
                if ({1'b0, pos} > body_start)
                begin
                    res.payload_length = 8'({1'b0, pos} - body_start);
                    res.body_hash = hash;
                end
                pending_results.push_back(res);
            end
            clear_packet();
        endfunction

        function void compare_field(string fname, logic [15:0] exp_v, logic [15:0] got_v);
            if (got_v !== exp_v)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h",
                             $realtime, fname, exp_v, got_v);
            end
        endfunction

        function void check_result(result_t got);
            result_t exp_r;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result item with none outstanding: 0x%0h", $realtime, got);
                return;
            end
            exp_r = pending_results.pop_front();
            compare_field("crc_error", exp_r.crc_error, got.crc_error);
            compare_field("header_byte", exp_r.header_byte, got.header_byte);
            compare_field("path_length_byte", exp_r.path_length_byte, got.path_length_byte);
            compare_field("has_transport", exp_r.has_transport, got.has_transport);
            compare_field("hop_hash_count", exp_r.hop_hash_count, got.hop_hash_count);
            compare_field("hop_hash_size", exp_r.hop_hash_size, got.hop_hash_size);
            compare_field("payload_length", exp_r.payload_length, got.payload_length);
            compare_field("body_hash", exp_r.body_hash, got.body_hash);
        endfunction
    endclass

    logic clk;
    logic rst_n;

    mphh_byte_if   pkt_if ();
    mphh_result_if res_if ();

    parse_hash_tracker sb;
    logic [7:0]        pkt_buf[$];
    bit                steady;
    bit                stall_request;

    mesh_packet_header_parse_hash #(
        .MAX_PACKET_BYTES (PKT_LIMIT)
    ) u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .pkt    (pkt_if),
        .result (res_if)
    );

    always #5 clk = ~clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 75)
            return 0;
        if (r < 96)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic send_byte(input logic [7:0] b, input bit last, input bit crc);
        int gap;
        gap = pick_gap();
        repeat (gap)
        begin
            @(negedge clk);
            pkt_if.valid <= 1'b0;
        end
        @(negedge clk);
        pkt_if.valid <= 1'b1;
        pkt_if.data_byte <= b;
        pkt_if.last_byte <= last;
        pkt_if.crc_bad <= crc;
        do
            @(posedge clk);
        while (!pkt_if.ready);
        sb.take_byte(b, last, crc);
    endtask

    task automatic send_packet(input bit crc_last);
        bit is_last;
        for (int i = 0; i < pkt_buf.size(); i++)
        begin
            is_last = (i == pkt_buf.size() - 1);
            send_byte(pkt_buf[i], is_last, is_last ? crc_last : bit'($urandom_range(0, 1)));
        end
    endtask

    function automatic void build_packet(int hops, int szc, int n_payload);
        logic [7:0] h;
        h = 8'($urandom);
        pkt_buf.delete();
        pkt_buf.push_back(h);
        if (h[1:0] == HDR_ROUTE_TRANSPORT_A || h[1:0] == HDR_ROUTE_TRANSPORT_B)
            repeat (4) pkt_buf.push_back(8'($urandom));
        pkt_buf.push_back({2'(szc), 6'(hops)});
        repeat (hops * (szc + 1)) pkt_buf.push_back(8'($urandom));
        repeat (n_payload) pkt_buf.push_back(8'($urandom));
    endfunction

    initial
    begin
        res_if.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            int stall;
            if (stall_request)
            begin
                stall = LONG_HOLD;
                stall_request = 1'b0;
            end
            else
            begin
                stall = pick_gap();
            end
            repeat (stall)
            begin
                @(negedge clk);
                res_if.ready <= 1'b0;
            end
            @(negedge clk);
            res_if.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        result_t got;
        if (rst_n && res_if.valid && res_if.ready)
        begin
            got.crc_error = res_if.crc_error;
            got.header_byte = res_if.header_byte;
            got.path_length_byte = res_if.path_length_byte;
            got.has_transport = res_if.has_transport;
            got.hop_hash_count = res_if.hop_hash_count;
            got.hop_hash_size = res_if.hop_hash_size;
            got.payload_length = res_if.payload_length;
            got.body_hash = res_if.body_hash;
            sb.check_result(got);
        end
    end

    initial
    begin
        #(LIMIT_NS);
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        int r;
        int random_bytes;
        int pkt_count;
        int overlong_sent;
        int hops;
        int n_drop;
        clk = 1'b0;
        rst_n = 1'b0;
        steady = 1'b0;
        stall_request = 1'b0;
        pkt_if.valid = 1'b0;
        pkt_if.data_byte = '0;
        pkt_if.last_byte = 1'b0;
        pkt_if.crc_bad = 1'b0;
        sb = new();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // one byte, with and without CRC failure
        pkt_buf = '{8'h5A};
        send_packet(1'b0);
        pkt_buf = '{8'hA5};
        send_packet(1'b1);
        // transport header, packet ends before the path length byte
        pkt_buf = '{8'h00, 8'hFF, 8'h00};
        send_packet(1'b0);
        // plain header, packet ends on the path length byte
        pkt_buf = '{8'h01, 8'h00};
        send_packet(1'b0);
        // longest path, runs past the end
        pkt_buf = '{8'hFF, 8'h11, 8'h22, 8'h33, 8'h44, 8'hFF, 8'hAA};
        send_packet(1'b0);
        pkt_buf = '{8'h02, 8'h41, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'h80};
        send_packet(1'b0);
        pkt_buf = '{8'h03, 8'h00, 8'h12};
        send_packet(1'b1);
        pkt_buf = '{8'hFE, 8'hC0, 8'h7F};
        send_packet(1'b0);

        random_bytes = 0;
        pkt_count = 0;
        overlong_sent = 0;
        while (random_bytes < RANDOM_BYTES)
        begin
            steady = (pkt_count >= 30 && pkt_count < 45);
            if (pkt_count == 60)
            begin
                // hold the result side while short packets keep coming
                stall_request = 1'b1;
                steady = 1'b1;
                repeat (10)
                begin
                    build_packet(0, $urandom_range(0, 3), $urandom_range(0, 2));
                    random_bytes += pkt_buf.size();
                    send_packet(1'b0);
                end
                steady = 1'b0;
            end
            r = $urandom_range(0, 99);
            hops = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 3);
            if (r < 75)
            begin
                build_packet(hops, $urandom_range(0, 3),
                             ($urandom_range(0, 9) == 0) ? $urandom_range(0, 60)
                                                         : $urandom_range(0, 16));
            end
            else if (r < 85)
            begin
                build_packet(hops, $urandom_range(0, 3), $urandom_range(0, 6));
                n_drop = $urandom_range(1, pkt_buf.size() - 1);
                repeat (n_drop) void'(pkt_buf.pop_back());
            end
            else if (r >= 97 && overlong_sent < 2)
            begin
                build_packet(0, 0, $urandom_range(255, 265));
                overlong_sent++;
            end
            else
            begin
                pkt_buf.delete();
                repeat ($urandom_range(1, 12)) pkt_buf.push_back(8'($urandom));
            end
            random_bytes += pkt_buf.size();
            send_packet($urandom_range(0, 19) == 0);
            pkt_count++;
        end

        @(negedge clk);
        pkt_if.valid <= 1'b0;
        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (sb.mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== files.f =====
design/mphh_pkg.sv
design/mphh_if.sv
design/mesh_packet_header_parse_hash.sv
tb/mesh_packet_header_parse_hash_tb.sv
